### src/bdel_pkg.sv
// shared types, codes and constants of the button debounce and e-stop latch block
package bdel_pkg;

	// configuration port
	localparam int CFG_W = 16;
	localparam int STAMP_IN_W = 48;
	localparam int CNT_W = 8;
	localparam int THR_W = 27;

	typedef enum logic [0:0] {
		CFG_LONG_PRESS = 1'b0,
		CFG_DEBOUNCE   = 1'b1
	} cfg_reg_t;

	localparam logic [15:0] LONG_PRESS_RESET = 16'd3000;
	localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd3;
	localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;
	localparam logic [9:0] US_PER_MS = 10'd1000;

	// queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	typedef enum logic [0:0] {
		KIND_SAMPLE = 1'b0,
		KIND_RESET  = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		EV_NONE         = 3'd0,
		EV_RUN_PRESS    = 3'd1,
		EV_RUN_RELEASE  = 3'd2,
		EV_STOP_PRESS   = 3'd3,
		EV_STOP_RELEASE = 3'd4,
		EV_STOP_LONG    = 3'd5,
		EV_ESTOP_ON     = 3'd6,
		EV_ESTOP_RESET  = 3'd7
	} event_t;

	typedef enum logic [1:0] {
		RS_NONE    = 2'd0,
		RS_CLEARED = 2'd1,
		RS_REFUSED = 2'd2
	} status_t;

	typedef struct packed {
		kind_t                 kind;
		logic                  run_level;
		logic                  stop_level;
		logic                  estop_level;
		logic [STAMP_IN_W-1:0] time_us;
	} in_item_t;

	typedef struct packed {
		event_t  event_res;
		status_t reset_status;
		logic    run_held;
		logic    stop_held;
		logic    estop_active;
		logic    last;
	} out_item_t;

	// one classified input transaction: up to three events plus the states after it
	typedef struct packed {
		event_t     ev0;
		event_t     ev1;
		event_t     ev2;
		logic [1:0] last_idx;
		status_t    status;
		logic       run_held;
		logic       stop_held;
		logic       estop_active;
	} job_t;

	typedef struct packed {
		logic             we;
		cfg_reg_t         addr;
		logic [CFG_W-1:0] data;
	} cfg_wr_t;

	// stop fires long once elapsed_us / 1000 > limit, i.e. elapsed_us >= (limit + 1) * 1000
	function automatic logic [THR_W-1:0] long_thresh(input logic [15:0] limit_ms);
		logic [THR_W-1:0] lim_ext;
		lim_ext = THR_W'(limit_ms) + THR_W'(1);
		return lim_ext * THR_W'(US_PER_MS);
	endfunction

endpackage

### src/button_debounce_estop_latch.sv
// top level of the debounced run/stop buttons with long press and latched e-stop
//
// Input side is a queue: drive in_data and push, a transaction is taken at a clock edge
// with push high and full low. A sample transaction (kind sample) debounces run and stop,
// checks the stop long press and updates the e-stop latch; a reset transaction tries
// to clear the latch and reports cleared or refused.
// Result side is a queue too: while empty is low the oldest result sits on out_data, and
// pop at an edge with empty low takes it. Each transaction gives one to three results,
// the final one marked by last.
// The front end classifies one transaction per cycle while full is low into a 4-deep
// job queue; the back end emits one result per cycle from the queue head through an
// output register while it is empty or popped. A taken transaction is queued, then
// its results enter the output register in turn, so sustained rate is one result per
// cycle, one transaction per cycle when each gives a single result. If pop stays low
// the output register holds, the queue fills and full rises; push is then refused
// until results drain. Reset empties the queue, clears all button and latch state and
// loads long press limit 3000 ms and debounce count 3. The user writes configuration
// (cfg_we, cfg_addr, cfg_data) only while no transaction is in flight; not enforced.
module button_debounce_estop_latch #(
	parameter int TIME_BITS = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  bdel_pkg::in_item_t             in_data,
	output logic                           empty,
	input  logic                           pop,
	output bdel_pkg::out_item_t            out_data,
	input  logic                           cfg_we,
	input  bdel_pkg::cfg_reg_t             cfg_addr,
	input  logic [bdel_pkg::CFG_W-1:0]     cfg_data
);

	bdel_pkg::cfg_wr_t cfg;
	bdel_pkg::job_t    job;
	bdel_pkg::job_t    head;
	logic              accept;
	logic              q_full;
	logic              q_nonempty;
	logic              deq;
	logic              out_valid;

	assign cfg.we   = cfg_we;
	assign cfg.addr = cfg_addr;
	assign cfg.data = cfg_data;
	assign accept   = push && !q_full;
	assign full     = q_full;
	assign empty    = !out_valid;

	// classification and state
	bdel_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.accept (accept),
		.item   (in_data),
		.job    (job)
	);

	// job queue
	bdel_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_job   (job),
		.rd_en    (deq),
		.rd_job   (head),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	// result sequencing
	bdel_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (q_nonempty),
		.pop        (pop),
		.deq        (deq),
		.out_valid  (out_valid),
		.out_item   (out_data)
	);

	// a reset transaction gives exactly one result with no event
	a_reset_single: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.reset_status != bdel_pkg::RS_NONE)
		|-> (out_data.last && out_data.event_res == bdel_pkg::EV_NONE))
		else $error("reset status on a non-final or event result");

	// long press only while stop is held
	a_long_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.event_res == bdel_pkg::EV_STOP_LONG) |-> out_data.stop_held)
		else $error("stop long event without stop held");

	// e-stop on leaves the latch set
	a_estop_on: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.event_res == bdel_pkg::EV_ESTOP_ON) |-> out_data.estop_active)
		else $error("estop on event with latch clear");

	// the back end never retires a job from an empty queue
	a_deq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		deq |-> q_nonempty)
		else $error("dequeue from empty job queue");

	// a popped non-final result is followed by more results of the same transaction
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !out_data.last) |=> !empty)
		else $error("result stream broken inside a transaction");

endmodule

### src/bdel_front.sv
// front end: debounce, long press and e-stop state, classifies each transaction into a job
module bdel_front #(
	parameter int TIME_BITS = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bdel_pkg::cfg_wr_t  cfg,
	input  logic               accept,
	input  bdel_pkg::in_item_t item,
	output bdel_pkg::job_t     job
);

	// configuration
	logic [bdel_pkg::THR_W-1:0] thresh_q;
	logic [bdel_pkg::CNT_W-1:0] debounce_q;

	// button state
	logic                       run_prev_q;
	logic [bdel_pkg::CNT_W-1:0] run_cnt_q;
	logic                       run_pressed_q;
	logic                       stop_prev_q;
	logic [bdel_pkg::CNT_W-1:0] stop_cnt_q;
	logic                       stop_pressed_q;
	logic [TIME_BITS-1:0]       stop_stamp_q;
	logic                       stop_fired_q;
	logic                       estop_latch_q;
	logic                       estop_prev_q;

	logic                       is_reset;
	logic                       run_raw;
	logic                       stop_raw;
	logic                       estop_pin;
	logic [TIME_BITS-1:0]       now;
	logic [bdel_pkg::CNT_W-1:0] run_cnt_nx;
	logic [bdel_pkg::CNT_W-1:0] stop_cnt_nx;
	logic                       run_chg;
	logic                       stop_deb;
	logic                       stop_chg;
	logic                       stop_pressed_nx;
	logic                       stop_fired_after;
	logic [TIME_BITS-1:0]       stop_stamp_nx;
	logic [TIME_BITS-1:0]       elapsed;
	logic                       long_hit;
	logic                       estop_on;
	logic                       estop_rel;
	logic                       estop_latch_nx;
	logic                       run_pressed_nx;
	bdel_pkg::event_t           ev_run;
	bdel_pkg::event_t           ev_stop;
	bdel_pkg::event_t           ev_estop;
	logic                       run_v;
	logic                       stop_v;
	logic                       estop_v;
	bdel_pkg::event_t           slot [3];
	logic [1:0]                 n_ev;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q   <= bdel_pkg::long_thresh(bdel_pkg::LONG_PRESS_RESET);
			debounce_q <= bdel_pkg::DEBOUNCE_RESET;
		end else if (cfg.we) begin
			unique case (cfg.addr)
				bdel_pkg::CFG_LONG_PRESS: thresh_q <= bdel_pkg::long_thresh(cfg.data);
				bdel_pkg::CFG_DEBOUNCE:   debounce_q <= cfg.data[bdel_pkg::CNT_W-1:0];
				default:                  debounce_q <= debounce_q;
			endcase
		end
	end

	// pin decode, pins are active low
	assign is_reset  = (item.kind == bdel_pkg::KIND_RESET);
	assign run_raw   = ~item.run_level;
	assign stop_raw  = ~item.stop_level;
	assign estop_pin = ~item.estop_level;
	assign now       = TIME_BITS'(item.time_us);

	// saturating stable counters
	always_comb begin
		if (run_raw != run_prev_q)
			run_cnt_nx = '0;
		else if (run_cnt_q == bdel_pkg::CNT_MAX)
			run_cnt_nx = bdel_pkg::CNT_MAX;
		else
			run_cnt_nx = run_cnt_q + bdel_pkg::CNT_W'(1);
		if (stop_raw != stop_prev_q)
			stop_cnt_nx = '0;
		else if (stop_cnt_q == bdel_pkg::CNT_MAX)
			stop_cnt_nx = bdel_pkg::CNT_MAX;
		else
			stop_cnt_nx = stop_cnt_q + bdel_pkg::CNT_W'(1);
	end

	// run debounce
	assign run_chg        = (run_cnt_nx >= debounce_q) && (run_raw != run_pressed_q);
	assign run_pressed_nx = run_chg ? run_raw : run_pressed_q;

	// stop debounce and long press
	assign stop_deb         = (stop_cnt_nx >= debounce_q);
	assign stop_chg         = stop_deb && (stop_raw != stop_pressed_q);
	assign stop_pressed_nx  = stop_chg ? stop_raw : stop_pressed_q;
	assign stop_fired_after = stop_chg ? 1'b0 : stop_fired_q;
	assign stop_stamp_nx    = (stop_chg && stop_raw) ? now : stop_stamp_q;
	assign elapsed          = now - stop_stamp_nx;
	assign long_hit = stop_deb && stop_pressed_nx && !stop_fired_after
		&& (elapsed >= TIME_BITS'(thresh_q));

	// e-stop latch
	assign estop_on  = estop_pin && !estop_latch_q;
	assign estop_rel = !estop_pin && estop_latch_q && estop_prev_q;
	always_comb begin
		if (is_reset)
			estop_latch_nx = estop_pin ? estop_latch_q : 1'b0;
		else
			estop_latch_nx = estop_latch_q | estop_pin;
	end

	// event candidates in output order
	assign run_v    = run_chg;
	assign ev_run   = run_raw ? bdel_pkg::EV_RUN_PRESS : bdel_pkg::EV_RUN_RELEASE;
	assign stop_v   = stop_chg || long_hit;
	assign ev_stop  = stop_chg ? (stop_raw ? bdel_pkg::EV_STOP_PRESS : bdel_pkg::EV_STOP_RELEASE)
		: bdel_pkg::EV_STOP_LONG;
	assign estop_v  = estop_on || estop_rel;
	assign ev_estop = estop_on ? bdel_pkg::EV_ESTOP_ON : bdel_pkg::EV_ESTOP_RESET;

	// pack the events into consecutive slots
	always_comb begin
		slot[0] = bdel_pkg::EV_NONE;
		slot[1] = bdel_pkg::EV_NONE;
		slot[2] = bdel_pkg::EV_NONE;
		n_ev    = 2'd0;
		if (!is_reset) begin
			if (run_v) begin
				slot[n_ev] = ev_run;
				n_ev = n_ev + 2'd1;
			end
			if (stop_v) begin
				slot[n_ev] = ev_stop;
				n_ev = n_ev + 2'd1;
			end
			if (estop_v) begin
				slot[n_ev] = ev_estop;
				n_ev = n_ev + 2'd1;
			end
		end
	end

	// job for the queue
	always_comb begin
		job.ev0          = slot[0];
		job.ev1          = slot[1];
		job.ev2          = slot[2];
		job.last_idx     = (n_ev == 2'd0) ? 2'd0 : n_ev - 2'd1;
		job.estop_active = estop_latch_nx;
		if (is_reset) begin
			job.status    = estop_pin ? bdel_pkg::RS_REFUSED : bdel_pkg::RS_CLEARED;
			job.run_held  = run_pressed_q;
			job.stop_held = stop_pressed_q;
		end else begin
			job.status    = bdel_pkg::RS_NONE;
			job.run_held  = run_pressed_nx;
			job.stop_held = stop_pressed_nx;
		end
	end

	// state update on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_prev_q     <= 1'b0;
			run_cnt_q      <= '0;
			run_pressed_q  <= 1'b0;
			stop_prev_q    <= 1'b0;
			stop_cnt_q     <= '0;
			stop_pressed_q <= 1'b0;
			stop_stamp_q   <= '0;
			stop_fired_q   <= 1'b0;
			estop_latch_q  <= 1'b0;
			estop_prev_q   <= 1'b0;
		end else if (accept) begin
			estop_latch_q <= estop_latch_nx;
			if (!is_reset) begin
				run_prev_q     <= run_raw;
				run_cnt_q      <= run_cnt_nx;
				run_pressed_q  <= run_pressed_nx;
				stop_prev_q    <= stop_raw;
				stop_cnt_q     <= stop_cnt_nx;
				stop_pressed_q <= stop_pressed_nx;
				stop_stamp_q   <= stop_stamp_nx;
				stop_fired_q   <= stop_fired_after || long_hit;
				estop_prev_q   <= estop_pin;
			end
		end
	end

endmodule

### src/bdel_fifo.sv
// short job queue between the front end and the result sequencer
module bdel_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  bdel_pkg::job_t wr_job,
	input  logic           rd_en,
	output bdel_pkg::job_t rd_job,
	output logic           full,
	output logic           nonempty
);

	bdel_pkg::job_t                   mem [bdel_pkg::FIFO_DEPTH];
	logic [bdel_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [bdel_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [bdel_pkg::FIFO_CNT_W-1:0] count_q;

	assign full     = (count_q == bdel_pkg::FIFO_CNT_W'(bdel_pkg::FIFO_DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_job   = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_ptr_q] <= wr_job;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + bdel_pkg::FIFO_PTR_W'(1);
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + bdel_pkg::FIFO_PTR_W'(1);
			if (wr_en && !rd_en)
				count_q <= count_q + bdel_pkg::FIFO_CNT_W'(1);
			else if (rd_en && !wr_en)
				count_q <= count_q - bdel_pkg::FIFO_CNT_W'(1);
		end
	end

endmodule

### src/bdel_back.sv
// back end: walks queued jobs, one result per cycle into the output register when free
module bdel_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bdel_pkg::job_t      head,
	input  logic                head_valid,
	input  logic                pop,
	output logic                deq,
	output logic                out_valid,
	output bdel_pkg::out_item_t out_item
);

	logic                out_valid_q;
	bdel_pkg::out_item_t out_q;
	logic [1:0]          idx_q;
	logic                slot_free;
	logic                take;
	logic                at_last;
	bdel_pkg::event_t    ev_sel;

	assign slot_free = !out_valid_q || pop;
	assign take      = slot_free && head_valid;
	assign at_last   = (idx_q == head.last_idx);
	assign deq       = take && at_last;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// pick the event at the current position in the job
	always_comb begin
		unique case (idx_q)
			2'd0:    ev_sel = head.ev0;
			2'd1:    ev_sel = head.ev1;
			2'd2:    ev_sel = head.ev2;
			default: ev_sel = bdel_pkg::EV_NONE;
		endcase
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take) begin
			out_q.event_res    <= ev_sel;
			out_q.reset_status <= head.status;
			out_q.run_held     <= head.run_held;
			out_q.stop_held    <= head.stop_held;
			out_q.estop_active <= head.estop_active;
			out_q.last         <= at_last;
		end
	end

	// output valid and position within the job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (take)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (deq)
				idx_q <= 2'd0;
			else if (take)
				idx_q <= idx_q + 2'd1;
		end
	end

endmodule

### dv/button_debounce_estop_latch_tb.sv
// testbench for the debounced run/stop buttons with long press and latched e-stop
module button_debounce_estop_latch_tb;

	localparam int unsigned CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	bdel_pkg::in_item_t in_data = '0;
	logic empty;
	logic pop = 1'b0;
	bdel_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	bdel_pkg::cfg_reg_t cfg_addr = bdel_pkg::CFG_LONG_PRESS;
	logic [bdel_pkg::CFG_W-1:0] cfg_data = '0;

	button_debounce_estop_latch u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_data(in_data),
		.empty(empty),
		.pop(pop),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	// panel transactions still to send and button reports still to arrive
	bdel_pkg::in_item_t button_inputs[$];
	bdel_pkg::out_item_t button_reports[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	logic [47:0] now_us = '0;

	// mirrored configuration
	logic [15:0] long_limit_ms = bdel_pkg::LONG_PRESS_RESET;
	logic [7:0] debounce_thr = bdel_pkg::DEBOUNCE_RESET;

	// mirrored button and latch state
	logic run_prev = 1'b0;
	logic [7:0] run_cnt = '0;
	logic run_down = 1'b0;
	logic stop_prev = 1'b0;
	logic [7:0] stop_cnt = '0;
	logic stop_down = 1'b0;
	logic [47:0] stop_stamp = '0;
	logic stop_long_done = 1'b0;
	logic estop_set = 1'b0;
	logic estop_was_active = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// saturating count of equal consecutive samples
	function automatic logic [7:0] next_count(input logic raw, input logic prev,
			input logic [7:0] cnt);
		if (raw != prev) begin
			return 8'd0;
		end
		return (cnt == bdel_pkg::CNT_MAX) ? bdel_pkg::CNT_MAX : cnt + 8'd1;
	endfunction

	// work out the reports one panel transaction causes
	task automatic debounce_and_latch(input bdel_pkg::in_item_t it);
		logic run_raw;
		logic stop_raw;
		logic estop_pin;
		logic [47:0] elapsed;
		bdel_pkg::event_t evs[3];
		int n;
		bdel_pkg::out_item_t r;
		run_raw = ~it.run_level;
		stop_raw = ~it.stop_level;
		estop_pin = ~it.estop_level;
		n = 0;
		r = '0;
		// latch reset request: one report, only the latch may change
		if (it.kind == bdel_pkg::KIND_RESET) begin
			if (!estop_pin) begin
				estop_set = 1'b0;
				r.reset_status = bdel_pkg::RS_CLEARED;
			end else begin
				r.reset_status = bdel_pkg::RS_REFUSED;
			end
			r.event_res = bdel_pkg::EV_NONE;
			r.run_held = run_down;
			r.stop_held = stop_down;
			r.estop_active = estop_set;
			r.last = 1'b1;
			button_reports.push_back(r);
			return;
		end
		// run debounce
		run_cnt = next_count(run_raw, run_prev, run_cnt);
		run_prev = run_raw;
		if (run_cnt >= debounce_thr && run_raw != run_down) begin
			run_down = run_raw;
			if (run_raw) begin
				evs[n] = bdel_pkg::EV_RUN_PRESS;
			end else begin
				evs[n] = bdel_pkg::EV_RUN_RELEASE;
			end
			n++;
		end
		// stop debounce and long press, only on debounced ticks
		stop_cnt = next_count(stop_raw, stop_prev, stop_cnt);
		stop_prev = stop_raw;
		if (stop_cnt >= debounce_thr) begin
			if (stop_raw != stop_down) begin
				stop_down = stop_raw;
				stop_long_done = 1'b0;
				if (stop_raw) begin
					stop_stamp = it.time_us;
					evs[n] = bdel_pkg::EV_STOP_PRESS;
				end else begin
					evs[n] = bdel_pkg::EV_STOP_RELEASE;
				end
				n++;
			end
			if (stop_down && !stop_long_done) begin
				elapsed = it.time_us - stop_stamp;
				if (elapsed / bdel_pkg::US_PER_MS > {32'd0, long_limit_ms}) begin
					stop_long_done = 1'b1;
					evs[n] = bdel_pkg::EV_STOP_LONG;
					n++;
				end
			end
		end
		// e-stop latch and release
		if (estop_pin && !estop_set) begin
			estop_set = 1'b1;
			evs[n] = bdel_pkg::EV_ESTOP_ON;
			n++;
		end
		if (!estop_pin && estop_set && estop_was_active) begin
			evs[n] = bdel_pkg::EV_ESTOP_RESET;
			n++;
		end
		estop_was_active = estop_pin;
		r.reset_status = bdel_pkg::RS_NONE;
		r.run_held = run_down;
		r.stop_held = stop_down;
		r.estop_active = estop_set;
		if (n == 0) begin
			r.event_res = bdel_pkg::EV_NONE;
			r.last = 1'b1;
			button_reports.push_back(r);
		end
		for (int k = 0; k < n; k++) begin
			r.event_res = evs[k];
			r.last = (k == n - 1);
			button_reports.push_back(r);
		end
	endtask

	// input side: one transaction per accepted push
	always @(posedge clk) begin : drive_inputs
		logic go;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				debounce_and_latch(button_inputs.pop_front());
			end
			go = (button_inputs.size() > 0) && ($urandom_range(0, 99) >= send_idle_pct);
			if (go) begin
				in_data <= button_inputs[0];
			end
			push <= go;
		end
	end

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// result side: compare each popped result with the oldest report
	always @(posedge clk) begin : watch_outputs
		bdel_pkg::out_item_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (button_reports.size() == 0) begin
					$error("result with no report pending: event_res %0d",
						out_data.event_res);
					fail_count++;
				end else begin
					want = button_reports.pop_front();
					check_field("event_res", want.event_res, out_data.event_res);
					check_field("reset_status", want.reset_status, out_data.reset_status);
					check_field("run_held", want.run_held, out_data.run_held);
					check_field("stop_held", want.stop_held, out_data.stop_held);
					check_field("estop_active", want.estop_active, out_data.estop_active);
					check_field("last", want.last, out_data.last);
				end
			end
			pop <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// run length guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("button_debounce_estop_latch_tb failed");
			$finish;
		end
	end

	task automatic add_sample(input logic run_lvl, input logic stop_lvl,
			input logic estop_lvl, input logic [47:0] step);
		bdel_pkg::in_item_t it;
		now_us = now_us + step;
		it.kind = bdel_pkg::KIND_SAMPLE;
		it.run_level = run_lvl;
		it.stop_level = stop_lvl;
		it.estop_level = estop_lvl;
		it.time_us = now_us;
		button_inputs.push_back(it);
	endtask

	// latch reset request; run, stop and time carry noise only
	task automatic add_latch_reset(input logic estop_lvl);
		bdel_pkg::in_item_t it;
		logic [63:0] wide;
		wide = {$urandom, $urandom};
		it.kind = bdel_pkg::KIND_RESET;
		it.run_level = wide[63];
		it.stop_level = wide[62];
		it.estop_level = estop_lvl;
		it.time_us = wide[47:0];
		button_inputs.push_back(it);
	endtask

	// mostly short steps, some long holds, now and then a jump anywhere
	task automatic advance_time();
		logic [63:0] wide;
		case ($urandom_range(0, 15))
			0: begin
				wide = {$urandom, $urandom};
				now_us = wide[47:0];
			end
			1, 2: begin
				now_us = now_us + 48'($urandom_range(0, 70000000));
			end
			default: begin
				now_us = now_us + 48'($urandom_range(1, 3000));
			end
		endcase
	endtask

	// hold one pin pattern long enough to debounce, with occasional glitches
	task automatic add_episode();
		logic r;
		logic s;
		logic e;
		logic [2:0] glitch;
		int unsigned len;
		r = 1'($urandom_range(0, 1));
		s = 1'($urandom_range(0, 1));
		e = ($urandom_range(0, 9) < 7);
		if ($urandom_range(0, 7) == 0) begin
			add_latch_reset(1'($urandom_range(0, 1)));
		end
		len = int'(debounce_thr) + $urandom_range(0, 3);
		repeat (len) begin
			glitch = ($urandom_range(0, 11) == 0) ? 3'(1 << $urandom_range(0, 2)) : 3'b000;
			advance_time();
			add_sample(r ^ glitch[0], s ^ glitch[1], e ^ glitch[2], 48'd0);
		end
	endtask

	task automatic write_reg(input bdel_pkg::cfg_reg_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bdel_pkg::CFG_LONG_PRESS) begin
			long_limit_ms = val;
		end else begin
			debounce_thr = val[7:0];
		end
	endtask

	// wait until every transaction is sent and every report is in
	task automatic drain();
		while (button_inputs.size() != 0 || button_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic random_phase(input int unsigned n_items);
		while (button_inputs.size() < n_items) begin
			add_episode();
		end
	endtask

	// sequence of phases
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 25;
		recv_idle_pct = 73;

		// directed: latch handling at reset settings
		add_latch_reset(1'b1);
		add_sample(1'b1, 1'b1, 1'b1, 48'd10);
		add_sample(1'b1, 1'b1, 1'b0, 48'd10);
		add_latch_reset(1'b0);
		add_sample(1'b1, 1'b1, 1'b1, 48'd10);
		add_latch_reset(1'b1);
		// three events in one tick, stop press stamped just short of time wrap
		now_us = 48'hFFFF_FFFF_F000;
		repeat (3) add_sample(1'b0, 1'b0, 1'b1, 48'd1);
		add_sample(1'b0, 1'b0, 1'b0, 48'd1);
		// long press boundary across the wrap: exactly the limit, then one past
		add_sample(1'b0, 1'b0, 1'b0, 48'd3000999);
		add_sample(1'b0, 1'b0, 1'b0, 48'd1);
		add_sample(1'b0, 1'b0, 1'b0, 48'd5000000);
		// release all, e-stop reset event on the first one
		repeat (4) add_sample(1'b1, 1'b1, 1'b1, 48'd1);
		add_latch_reset(1'b1);
		now_us = '1;
		add_sample(1'b1, 1'b1, 1'b1, 48'd0);
		drain();

		// largest debounce count; stable count saturates when the press debounces, before the long press
		write_reg(bdel_pkg::CFG_DEBOUNCE, 16'd255);
		write_reg(bdel_pkg::CFG_LONG_PRESS, 16'd0);
		@(negedge clk);
		repeat (262) add_sample(1'b0, 1'b0, 1'b1, 48'd600);
		drain();

		// random: fastest debounce, shortest long press
		write_reg(bdel_pkg::CFG_DEBOUNCE, 16'd1);
		write_reg(bdel_pkg::CFG_LONG_PRESS, 16'd0);
		@(negedge clk);
		random_phase(40);
		drain();

		// random: longest long press, receiver mostly ready
		write_reg(bdel_pkg::CFG_DEBOUNCE, 16'($urandom_range(1, 8)));
		write_reg(bdel_pkg::CFG_LONG_PRESS, 16'hFFFF);
		@(negedge clk);
		send_idle_pct = 73;
		recv_idle_pct = 25;
		random_phase(40);
		drain();

		// random: middle settings, no idling
		write_reg(bdel_pkg::CFG_DEBOUNCE, 16'($urandom_range(1, 6)));
		write_reg(bdel_pkg::CFG_LONG_PRESS, 16'($urandom_range(0, 20)));
		@(negedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(40);
		drain();

		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("button_debounce_estop_latch_tb passed");
		end else begin
			$display("button_debounce_estop_latch_tb failed");
		end
		$finish;
	end

endmodule
